FILE: rtl/csucc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csucc_pkg
// Shared widths, codes, state type and control structs of the combination
// successor block.
// ----------------------------------------------------------------------------
package csucc_pkg;

  // default sizes of the slot store and of the index set
  localparam int unsigned MAX_SET_DEF    = 64;
  localparam int unsigned MAX_CHOOSE_DEF = 16;

  // fixed field widths
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned SET_W      = 7;
  localparam int unsigned CHOOSE_W   = 5;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CMP_W      = 8;

  // register reset values
  localparam logic [SET_W-1:0]    SET_SIZE_RST     = 7'd64;
  localparam logic [CHOOSE_W-1:0] CHOOSE_COUNT_RST = 5'd1;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SET_SIZE     = 1'b0,
    CFG_CHOOSE_COUNT = 1'b1
  } cfg_reg_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_INVAL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic restart;     // reload first combination
    logic scan_init;   // arm the carry scan at the last slot
    logic scan_en;     // carry scan running
    logic carry_load;  // latch carry slot and its new value
    logic emit_en;     // emit pass running
    logic set_exh;     // enter exhausted state
    logic inval_load;  // load the invalid result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_comb;     // k is zero or above n
    logic exhausted;
    logic found;       // carry slot found this cycle
    logic not_found;   // scan reached slot zero without a carry
    logic emit_done;   // all results of the pass handed to the output stage
    logic out_free;    // output register can take a result this cycle
    logic s1_busy;     // read stage holds a result
  } sts_t;

endpackage

FILE: rtl/csucc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csucc_ram
// Generic simple dual-port RAM, one write and one read port, registered read
// with read enable.
// ----------------------------------------------------------------------------
module csucc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/csucc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csucc_ctrl
// Sequencer of the combination successor: accept, carry scan, emit pass and
// invalid result.
// ----------------------------------------------------------------------------
module csucc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_restart_i,
  input  csucc_pkg::sts_t   sts_i,
  output csucc_pkg::cmd_t   cmd_o
);

  csucc_pkg::state_e state_q, state_d;
  logic              accept;

  assign accept = in_valid_i && (state_q == csucc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csucc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csucc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_restart_i) begin
            state_d = sts_i.no_comb ? csucc_pkg::ST_INVAL : csucc_pkg::ST_EMIT;
          end else if (sts_i.exhausted || sts_i.no_comb) begin
            state_d = csucc_pkg::ST_INVAL;
          end else begin
            state_d = csucc_pkg::ST_SCAN;
          end
        end
      end
      csucc_pkg::ST_SCAN: begin
        if (sts_i.found) begin
          state_d = csucc_pkg::ST_EMIT;
        end else if (sts_i.not_found) begin
          state_d = csucc_pkg::ST_INVAL;
        end
      end
      csucc_pkg::ST_EMIT: begin
        if (sts_i.emit_done) begin
          state_d = csucc_pkg::ST_IDLE;
        end
      end
      csucc_pkg::ST_INVAL: begin
        if (sts_i.out_free) begin
          state_d = csucc_pkg::ST_IDLE;
        end
      end
      default: state_d = csucc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      csucc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (in_restart_i) begin
            cmd_o.restart = 1'b1;
          end else if (sts_i.exhausted || sts_i.no_comb) begin
            cmd_o.set_exh = 1'b1;
          end else begin
            cmd_o.scan_init = 1'b1;
          end
        end
      end
      csucc_pkg::ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.found) begin
          cmd_o.carry_load = 1'b1;
        end else if (sts_i.not_found) begin
          cmd_o.set_exh = 1'b1;
        end
      end
      csucc_pkg::ST_EMIT: begin
        cmd_o.emit_en = 1'b1;
      end
      csucc_pkg::ST_INVAL: begin
        cmd_o.inval_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/csucc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csucc_dp
// Datapath: configuration registers, slot store with valid bits, carry scan,
// refill and emit pipeline, output register.
// ----------------------------------------------------------------------------
module csucc_dp #(
  parameter int unsigned MAX_SET    = csucc_pkg::MAX_SET_DEF,
  parameter int unsigned MAX_CHOOSE = csucc_pkg::MAX_CHOOSE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [csucc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [csucc_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  csucc_pkg::cmd_t                    cmd_i,
  output csucc_pkg::sts_t                    sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [csucc_pkg::INDEX_W-1:0]      out_index_o,
  output logic [csucc_pkg::POS_W-1:0]        out_position_o,
  output logic                               out_last_o,
  output logic                               out_valid_res_o
);

  localparam int unsigned IW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
  localparam int unsigned KW = $clog2(MAX_CHOOSE + 1);
  localparam int unsigned XW = csucc_pkg::INDEX_W;

  // configuration
  logic [csucc_pkg::SET_W-1:0]    set_size_q;
  logic [csucc_pkg::CHOOSE_W-1:0] choose_q;
  logic [csucc_pkg::SET_W-1:0]    n_eff;
  logic [KW-1:0]                  k_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q <= csucc_pkg::SET_SIZE_RST;
      choose_q   <= csucc_pkg::CHOOSE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        csucc_pkg::CFG_SET_SIZE:     set_size_q <= cfg_wdata_i[csucc_pkg::SET_W-1:0];
        csucc_pkg::CFG_CHOOSE_COUNT: choose_q   <= cfg_wdata_i[csucc_pkg::CHOOSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (32'(set_size_q) > 32'(MAX_SET)) ? csucc_pkg::SET_W'(MAX_SET) : set_size_q;
  assign k_eff = (32'(choose_q) > 32'(MAX_CHOOSE)) ? KW'(MAX_CHOOSE) : KW'(choose_q);

  logic no_comb;
  assign no_comb = (k_eff == '0) ||
                   (csucc_pkg::CMP_W'(k_eff) > csucc_pkg::CMP_W'(n_eff));

  // slot store
  logic [MAX_CHOOSE-1:0] slot_vld_q;
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [XW-1:0]         ram_wdata, ram_rdata;

  csucc_ram #(
    .WIDTH (XW),
    .DEPTH (MAX_CHOOSE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic exh_q;

  // carry scan
  logic [IW-1:0]            rd_i_q;
  logic [IW-1:0]            cmp_i_q;
  logic                     cmp_v_q;
  logic                     cmp_slot_vld_q;
  logic [XW-1:0]            cmp_val;
  logic [csucc_pkg::CMP_W-1:0] cmp_lim;
  logic                     grow;

  assign cmp_val = cmp_slot_vld_q ? ram_rdata : XW'(cmp_i_q);
  assign cmp_lim = csucc_pkg::CMP_W'(n_eff) - csucc_pkg::CMP_W'(k_eff)
                   + csucc_pkg::CMP_W'(cmp_i_q);
  assign grow    = csucc_pkg::CMP_W'(cmp_val) < cmp_lim;

  // emit pass
  logic [KW-1:0] p_q;
  logic [KW-1:0] carry_q;
  logic [XW-1:0] carry_val_q;
  logic [IW-1:0] p_idx;
  logic          p_live, p_refill, issue;
  logic [XW-1:0] fill_val;

  logic                       s1_v_q;
  logic                       s1_ram_q;
  logic [XW-1:0]              s1_calc_q;
  logic [csucc_pkg::POS_W-1:0] s1_pos_q;
  logic                       s1_last_q;
  logic                       s1_move;

  logic                       o_v_q;
  logic [XW-1:0]              o_index_q;
  logic [csucc_pkg::POS_W-1:0] o_pos_q;
  logic                       o_last_q;
  logic                       o_vres_q;
  logic                       out_free;

  assign p_idx    = p_q[IW-1:0];
  assign p_live   = p_q < k_eff;
  assign p_refill = p_q >= carry_q;
  assign fill_val = carry_val_q + XW'(p_q - carry_q);

  assign out_free = !o_v_q || out_ready_i;
  assign s1_move  = s1_v_q && out_free;
  assign issue    = cmd_i.emit_en && p_live && (!s1_v_q || s1_move);

  // memory port selection
  assign ram_re    = cmd_i.scan_en || issue;
  assign ram_raddr = cmd_i.scan_en ? rd_i_q : p_idx;
  assign ram_we    = issue && p_refill;
  assign ram_waddr = p_idx;
  assign ram_wdata = fill_val;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      exh_q      <= 1'b0;
      cmp_v_q    <= 1'b0;
      s1_v_q     <= 1'b0;
      o_v_q      <= 1'b0;
      rd_i_q     <= '0;
      p_q        <= '0;
      carry_q    <= '0;
    end else begin
      if (cmd_i.restart) begin
        slot_vld_q <= '0;
        exh_q      <= no_comb;
        carry_q    <= k_eff;
        p_q        <= '0;
      end
      if (cmd_i.set_exh) begin
        exh_q <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        rd_i_q  <= IW'(k_eff - KW'(1));
        cmp_v_q <= 1'b0;
      end
      if (cmd_i.scan_en) begin
        cmp_v_q <= 1'b1;
        if (rd_i_q != '0) begin
          rd_i_q <= rd_i_q - IW'(1);
        end
      end
      if (cmd_i.carry_load) begin
        carry_q <= KW'(cmp_i_q);
        p_q     <= '0;
      end
      if (ram_we) begin
        slot_vld_q[p_idx] <= 1'b1;
      end
      if (issue) begin
        p_q <= p_q + KW'(1);
      end
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move || cmd_i.inval_load) begin
        o_v_q <= 1'b1;
      end else if (out_ready_i) begin
        o_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      cmp_i_q        <= rd_i_q;
      cmp_slot_vld_q <= slot_vld_q[rd_i_q];
    end
    if (cmd_i.carry_load) begin
      carry_val_q <= cmp_val + XW'(1);
    end
    if (issue) begin
      s1_ram_q  <= !p_refill && slot_vld_q[p_idx];
      s1_calc_q <= p_refill ? fill_val : XW'(p_q);
      s1_pos_q  <= csucc_pkg::POS_W'(p_q);
      s1_last_q <= (p_q == k_eff - KW'(1));
    end
    if (s1_move) begin
      o_index_q <= s1_ram_q ? ram_rdata : s1_calc_q;
      o_pos_q   <= s1_pos_q;
      o_last_q  <= s1_last_q;
      o_vres_q  <= 1'b1;
    end else if (cmd_i.inval_load) begin
      o_index_q <= '0;
      o_pos_q   <= '0;
      o_last_q  <= 1'b1;
      o_vres_q  <= 1'b0;
    end
  end

  // status
  always_comb begin
    sts_o           = '0;
    sts_o.no_comb   = no_comb;
    sts_o.exhausted = exh_q;
    sts_o.found     = cmd_i.scan_en && cmp_v_q && grow;
    sts_o.not_found = cmd_i.scan_en && cmp_v_q && !grow && (cmp_i_q == '0);
    sts_o.emit_done = !p_live && (!s1_v_q || s1_move);
    sts_o.out_free  = out_free;
    sts_o.s1_busy   = s1_v_q;
  end

  assign out_valid_o     = o_v_q;
  assign out_index_o     = o_index_q;
  assign out_position_o  = o_pos_q;
  assign out_last_o      = o_last_q;
  assign out_valid_res_o = o_vres_q;

endmodule

FILE: rtl/combination_successor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combination_successor
// Lexicographic k-of-n combination generator: restart loads 0..k-1, advance
// steps to the next combination; each item emits the combination one index
// per transfer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  payload
//  in        in   in_valid_i / in_ready_o    in_restart_i
//  out       out  out_valid_o / out_ready_i  out_index_o, out_position_o,
//                                            out_last_o, out_valid_res_o
//  cfg       in   cfg_we_i (no wait)         cfg_addr_i, cfg_wdata_i
//
//  one item at a time; the slots live in a single-read-port RAM
//  restart: accept, then the emit pass (k reads and a drain)
//  advance: accept, carry scan from the last slot down to the carry slot,
//    then the emit pass; the order is set by the one RAM read port
//  exhausted or no combination: one invalid transfer
//  reset clears the slot valid bits so every slot reads as its own number;
//    no clearing pass is needed
//  output stalls freeze the emit pass; the next item is taken while the last
//    result still sits in the output register
//
module combination_successor #(
  parameter int unsigned MAX_SET    = csucc_pkg::MAX_SET_DEF,
  parameter int unsigned MAX_CHOOSE = csucc_pkg::MAX_CHOOSE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [csucc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [csucc_pkg::CFG_W-1:0]      cfg_wdata_i,
  // item channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             in_restart_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [csucc_pkg::INDEX_W-1:0]    out_index_o,
  output logic [csucc_pkg::POS_W-1:0]      out_position_o,
  output logic                             out_last_o,
  output logic                             out_valid_res_o
);

  csucc_pkg::cmd_t cmd;
  csucc_pkg::sts_t sts;

  // sequencer: accept, scan, emit, invalid result
  csucc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_restart_i (in_restart_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // slot store, carry scan, refill and output stage
  csucc_dp #(
    .MAX_SET    (MAX_SET),
    .MAX_CHOOSE (MAX_CHOOSE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_index_o     (out_index_o),
    .out_position_o  (out_position_o),
    .out_last_o      (out_last_o),
    .out_valid_res_o (out_valid_res_o)
  );

`ifndef SYNTHESIS
  // an invalid result is a one-transfer run with zero index
  a_inval_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_valid_res_o) |-> (out_last_o && out_index_o == '0))
    else $error("invalid result with bad shape");

  // a new item is only taken once the read stage has drained
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.s1_busy)
    else $error("item accepted while read stage busy");

  // the scan ends in exactly one way
  a_scan_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.found && sts.not_found))
    else $error("carry scan found and failed at once");

  // a scan start always comes with an advance transfer
  a_scan_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_init |-> (in_valid_i && in_ready_o && !in_restart_i))
    else $error("scan started without an advance transfer");
`endif

endmodule

FILE: test/combination_successor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combination_successor_test
// Self-checking bench for the k-of-n combination successor. A scoreboard
// class predicts every result transfer from the accepted items and the
// register writes, and checks the result channel field by field. A short
// directed run covers the corner cases; random phases of restart/advance
// runs follow, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module combination_successor_test;
  import csucc_pkg::*;

  localparam real         CLK_PERIOD     = 2.0;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned MAX_GAP        = 17;
  // long enough for the longest item, so this covers a busy block
  localparam int unsigned DRAIN_CYCLES   = 2 * MAX_CHOOSE_DEF + 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  // cycles without any transfer; the hold-off plus a drain is the longest
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 330;
  localparam int unsigned MAX_PRINTS     = 100;

  // one result transfer as seen on the output channel
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [POS_W-1:0]   position;
    logic               last;
    logic               valid_res;
  } comb_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the slots, the exhausted flag and the registers
  // --------------------------------------------------------------------------
  class comb_scoreboard;
    logic [INDEX_W-1:0]  slots[MAX_CHOOSE_DEF];
    bit                  spent;
    logic [SET_W-1:0]    set_size;
    logic [CHOOSE_W-1:0] choose_count;
    comb_result_t        expected[$];
    int unsigned         mismatches;

    function new();
      foreach (slots[i]) slots[i] = INDEX_W'(i);
      spent        = 1'b0;
      set_size     = SET_SIZE_RST;
      choose_count = CHOOSE_COUNT_RST;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_reg_e which, logic [CFG_W-1:0] value);
      case (which)
        CFG_SET_SIZE:     set_size     = value[SET_W-1:0];
        CFG_CHOOSE_COUNT: choose_count = value[CHOOSE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // works out the next combination and queues the results it causes
    function void note_item(bit restart);
      int n;
      int k;
      int s;
      bit found;
      // oversized registers saturate at the store sizes
      n = (set_size > MAX_SET_DEF) ? MAX_SET_DEF : int'(set_size);
      k = (choose_count > MAX_CHOOSE_DEF) ? MAX_CHOOSE_DEF : int'(choose_count);
      found = 1'b0;
      if (restart) begin
        foreach (slots[i]) slots[i] = INDEX_W'(i);
        spent = (k == 0 || k > n);
      end else if (!spent) begin
        if (k == 0 || k > n) begin
          spent = 1'b1;
        end else begin
          // rightmost slot still below its ceiling n - k + slot
          s = k;
          while (s > 0 && !found) begin
            s--;
            if (int'(slots[s]) < n - k + s) found = 1'b1;
          end
          if (!found) begin
            spent = 1'b1;   // past the final combination, slots kept
          end else begin
            slots[s] = slots[s] + 1'b1;
            for (int j = s + 1; j < k; j++) slots[j] = slots[j-1] + 1'b1;
          end
        end
      end
      if (spent) begin
        expected.push_back('{'0, '0, 1'b1, 1'b0});
      end else begin
        for (int p = 0; p < k; p++)
          expected.push_back('{slots[p], POS_W'(p), (p == k - 1), 1'b1});
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(comb_result_t got);
      comb_result_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d position %0d",
                                  got.index, got.position));
      end else begin
        want = expected.pop_front();
        if (got.index !== want.index)
          report_mismatch($sformatf("index %0d, want %0d", got.index, want.index));
        if (got.position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", got.position,
                                    want.position));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b (index %0d)", got.last,
                                    want.last, want.index));
        if (got.valid_res !== want.valid_res)
          report_mismatch($sformatf("valid_res %b, want %b", got.valid_res,
                                    want.valid_res));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block inputs start known; outputs
  // --------------------------------------------------------------------------
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i   = '0;
  logic [CFG_W-1:0]      cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_restart_i = 1'b0;
  logic                  out_ready_i  = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [INDEX_W-1:0]    out_index_o;
  logic [POS_W-1:0]      out_position_o;
  logic                  out_last_o;
  logic                  out_valid_res_o;

  comb_scoreboard sb = new();

  // knobs shared by the stimulus and the result side
  bit          tx_quiet     = 1'b0;  // sender offers back to back
  bit          rx_quiet     = 1'b0;  // receiver stalls only on a hold request
  bit          hold_req     = 1'b0;  // ask the receiver for one long hold-off
  int unsigned items_sent   = 0;
  int unsigned idle_cycles  = 0;

  combination_successor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_restart_i   (in_restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_index_o    (out_index_o),
    .out_position_o (out_position_o),
    .out_last_o     (out_last_o),
    .out_valid_res_o(out_valid_res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // watchdog: give up when no transfer happens on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stall before each transfer, one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req) begin
        // block fills up behind this and must stall its input
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      // ready is high at every edge seen here, so valid alone marks a transfer
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result('{out_index_o, out_position_o, out_last_o, out_valid_res_o});
    end
  end

  // --------------------------------------------------------------------------
  // item side
  // --------------------------------------------------------------------------

  // offer one item after a random gap; valid stays up when there is no gap
  task automatic push_item(bit restart);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_restart_i <= restart;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_item(restart);
    items_sent++;
  endtask

  // stop offering, wait for every expected result, then let the block go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // both registers, one write per cycle, only while the block is idle
  task automatic configure(logic [CFG_W-1:0] n, logic [CFG_W-1:0] k);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_SET_SIZE;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    sb.write_reg(CFG_SET_SIZE, n);
    cfg_addr_i  <= CFG_CHOOSE_COUNT;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    sb.write_reg(CFG_CHOOSE_COUNT, k);
    cfg_we_i    <= 1'b0;
  endtask

  // a well-formed run: optional restart, then advances with a few stray restarts
  task automatic run_walk(bit lead_restart, int unsigned advances);
    if (lead_restart) push_item(1'b1);
    repeat (advances) push_item($urandom_range(0, 19) == 0);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned n;
    int unsigned target;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed corner cases ----------------
    // reset registers (n = 64, k = 1): advance straight from the reset slots
    push_item(1'b0);
    push_item(1'b0);
    push_item(1'b1);
    push_item(1'b0);
    // oversized set and choice saturate to 64 and 16: all sixteen positions
    configure(7'd127, 7'd31);
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b0);
    // n = k = 16: one combination, then advance past the end, stay exhausted
    configure(7'd16, 7'd16);
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b0);
    push_item(1'b1);
    // empty set: no combination on restart or advance
    configure(7'd0, 7'd1);
    push_item(1'b1);
    push_item(1'b0);
    // zero choice: advance before restart, then restart
    configure(7'd5, 7'd0);
    push_item(1'b0);
    push_item(1'b1);
    // choice above set size
    configure(7'd3, 7'd5);
    push_item(1'b1);
    // ordinary 2-of-5 run
    configure(7'd5, 7'd2);
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b0);
    push_item(1'b0);
    // registers changed with no restart: advance on the stored slots
    configure(7'd7, 7'd3);
    push_item(1'b0);
    push_item(1'b0);
    configure(7'd4, 7'd3);
    push_item(1'b0);
    push_item(1'b0);

    // ---------------- random phases ----------------
    target = items_sent + RANDOM_ITEMS;

    // output held off for a long stretch while items keep coming
    configure(7'd10, 7'd5);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    hold_req = 1'b1;
    run_walk(1'b1, 11);

    // long walk so the indices climb to the top of the 64-element set
    configure(7'd64, 7'($urandom_range(1, 2)));
    tx_quiet = ($urandom_range(0, 1) == 0);
    rx_quiet = ($urandom_range(0, 1) == 0);
    run_walk(1'b1, 66);

    while (items_sent < target) begin
      kind     = $urandom_range(0, 9);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (kind == 0) begin
        // large sizes, including the saturating ones, only a few items
        configure(7'($urandom_range(17, 127)), 7'($urandom_range(9, 31)));
        run_walk(1'b1, $urandom_range(1, 3));
      end else if (kind == 1) begin
        // tiny or empty sets with any choice, mostly no combination
        configure(7'($urandom_range(0, 3)), 7'($urandom_range(0, 31)));
        run_walk($urandom_range(0, 1), 3);
      end else begin
        // small sets walked through to exhaustion and beyond
        n = $urandom_range(1, 8);
        configure(7'(n), 7'($urandom_range(1, n)));
        run_walk($urandom_range(0, 9) != 0, $urandom_range(4, 30));
      end
    end

    // ---------------- wrap up ----------------
    settle();
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
